FILE: hdl/rrfa_pkg.sv
// Shared widths, register indexes and types of the record range filter.
`default_nettype none

package rrfa_pkg;

  localparam int EpochW      = 40;
  localparam int DelayW      = 32;
  localparam int BytesW      = 40;
  localparam int OutW        = 41;
  localparam int BoundW      = 41;
  localparam int DelayBoundW = 33;
  localparam int CntW        = 40;
  localparam int SumW        = 63;
  localparam int SumXW       = SumW + 1;
  localparam int IdxW        = 4;
  localparam int CfgDataW    = 41;

  typedef enum logic [IdxW-1:0] {
    REG_EPOCH_LOW      = 4'd0,
    REG_EPOCH_HIGH     = 4'd1,
    REG_IN_BYTES_LOW   = 4'd2,
    REG_IN_BYTES_HIGH  = 4'd3,
    REG_OUT_BYTES_LOW  = 4'd4,
    REG_OUT_BYTES_HIGH = 4'd5,
    REG_DELAY_LOW      = 4'd6,
    REG_DELAY_HIGH     = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [BoundW-1:0]      epoch_low;
    logic signed [BoundW-1:0]      epoch_high;
    logic signed [BoundW-1:0]      in_bytes_low;
    logic signed [BoundW-1:0]      in_bytes_high;
    logic signed [BoundW-1:0]      out_bytes_low;
    logic signed [BoundW-1:0]      out_bytes_high;
    logic signed [DelayBoundW-1:0] delay_low;
    logic signed [DelayBoundW-1:0] delay_high;
  } bounds_t;

  typedef struct packed {
    logic [EpochW-1:0]      epoch;
    logic [DelayW-1:0]      delay;
    logic [BytesW-1:0]      in_size;
    logic signed [OutW-1:0] out_size;
  } record_t;

  // Filter verdict and addends handed to the accumulator stage
  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [BytesW-1:0] in_add;
    logic [BytesW-1:0] out_add;
  } stage_t;

endpackage

`default_nettype wire

FILE: hdl/rrfa_if.sv
// Channel interfaces: record input, result output and configuration write.
`default_nettype none

interface rrfa_rec_if;
  logic                                valid;
  logic                                ready;
  logic [rrfa_pkg::EpochW-1:0]         record_epoch;
  logic [rrfa_pkg::DelayW-1:0]         record_delay;
  logic [rrfa_pkg::BytesW-1:0]         record_in_bytes;
  logic signed [rrfa_pkg::OutW-1:0]    record_out_bytes;

  modport source (output valid, record_epoch, record_delay, record_in_bytes,
                  record_out_bytes, input ready);
  modport sink (input valid, record_epoch, record_delay, record_in_bytes,
                record_out_bytes, output ready);
endinterface

interface rrfa_res_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [rrfa_pkg::CntW-1:0]   access_total;
  logic [rrfa_pkg::SumW-1:0]   in_bytes_total;
  logic [rrfa_pkg::SumW-1:0]   out_bytes_total;

  modport source (output valid, accepted, access_total, in_bytes_total,
                  out_bytes_total, input ready);
  modport sink (input valid, accepted, access_total, in_bytes_total,
                out_bytes_total, output ready);
endinterface

interface rrfa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rrfa_pkg::IdxW-1:0]       index;
  logic [rrfa_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/rrfa_cfg_regs.sv
// Bound registers, written through the configuration channel.
`default_nettype none

module rrfa_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_i,
  input  wire logic [rrfa_pkg::IdxW-1:0]     idx_i,
  input  wire logic [rrfa_pkg::CfgDataW-1:0] data_i,
  output rrfa_pkg::bounds_t                  bounds_o
);

  rrfa_pkg::bounds_t bounds_q, bounds_d;

  always_comb begin
    bounds_d = bounds_q;
    if (wr_i) begin
      case (rrfa_pkg::reg_idx_e'(idx_i))
        rrfa_pkg::REG_EPOCH_LOW:      bounds_d.epoch_low      = data_i;
        rrfa_pkg::REG_EPOCH_HIGH:     bounds_d.epoch_high     = data_i;
        rrfa_pkg::REG_IN_BYTES_LOW:   bounds_d.in_bytes_low   = data_i;
        rrfa_pkg::REG_IN_BYTES_HIGH:  bounds_d.in_bytes_high  = data_i;
        rrfa_pkg::REG_OUT_BYTES_LOW:  bounds_d.out_bytes_low  = data_i;
        rrfa_pkg::REG_OUT_BYTES_HIGH: bounds_d.out_bytes_high = data_i;
        rrfa_pkg::REG_DELAY_LOW:
          bounds_d.delay_low  = data_i[rrfa_pkg::DelayBoundW-1:0];
        rrfa_pkg::REG_DELAY_HIGH:
          bounds_d.delay_high = data_i[rrfa_pkg::DelayBoundW-1:0];
        default: ; // unknown index: write dropped
      endcase
    end
  end

  // all bounds come out of reset disabled (-1)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= '1;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  assign bounds_o = bounds_q;

endmodule

`default_nettype wire

FILE: hdl/rrfa_filter.sv
// Input register and bound checks; forms the addends for the accumulators.
`default_nettype none

module rrfa_filter (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic             take_i,
  input  wire rrfa_pkg::record_t rec_i,
  input  wire rrfa_pkg::bounds_t bounds_i,
  output rrfa_pkg::stage_t      stage_o
);

  logic              valid_q, valid_d;
  rrfa_pkg::record_t rec_q;

  logic signed [rrfa_pkg::BoundW-1:0]      epoch_s, inb_s, eff;
  logic signed [rrfa_pkg::DelayBoundW-1:0] delay_s;
  logic                                    ok;

  // a negative bound is off; low inclusive, high exclusive
  function automatic logic pass41(input logic signed [rrfa_pkg::BoundW-1:0] v,
                                  input logic signed [rrfa_pkg::BoundW-1:0] lo,
                                  input logic signed [rrfa_pkg::BoundW-1:0] hi);
    logic fail;
    fail = (!lo[rrfa_pkg::BoundW-1] && (v < lo)) ||
           (!hi[rrfa_pkg::BoundW-1] && (v >= hi));
    return !fail;
  endfunction

  function automatic logic pass33(
    input logic signed [rrfa_pkg::DelayBoundW-1:0] v,
    input logic signed [rrfa_pkg::DelayBoundW-1:0] lo,
    input logic signed [rrfa_pkg::DelayBoundW-1:0] hi);
    logic fail;
    fail = (!lo[rrfa_pkg::DelayBoundW-1] && (v < lo)) ||
           (!hi[rrfa_pkg::DelayBoundW-1] && (v >= hi));
    return !fail;
  endfunction

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  always_comb begin
    epoch_s = $signed({1'b0, rec_q.epoch});
    inb_s   = $signed({1'b0, rec_q.in_size});
    delay_s = $signed({1'b0, rec_q.delay});
    ok = pass41(epoch_s, bounds_i.epoch_low, bounds_i.epoch_high) &&
         pass41(inb_s, bounds_i.in_bytes_low, bounds_i.in_bytes_high) &&
         pass41(rec_q.out_size, bounds_i.out_bytes_low, bounds_i.out_bytes_high) &&
         pass33(delay_s, bounds_i.delay_low, bounds_i.delay_high);
    // outgoing of -1 means same as incoming; other negatives add nothing
    eff = (rec_q.out_size == '1) ? inb_s : rec_q.out_size;
    stage_o.valid   = valid_q;
    stage_o.ok      = ok;
    stage_o.in_add  = rec_q.in_size;
    stage_o.out_add = eff[rrfa_pkg::BoundW-1] ? '0 : eff[rrfa_pkg::BytesW-1:0];
  end

endmodule

`default_nettype wire

FILE: hdl/rrfa_accum.sv
// Saturating access count and byte totals; doubles as the result register.
`default_nettype none

module rrfa_accum (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rrfa_pkg::stage_t           stage_i,
  output logic                            take_o,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output logic                            accepted_o,
  output logic [rrfa_pkg::CntW-1:0]       access_total_o,
  output logic [rrfa_pkg::SumW-1:0]       in_bytes_total_o,
  output logic [rrfa_pkg::SumW-1:0]       out_bytes_total_o
);

  logic                         res_valid_q, res_valid_d;
  logic                         accepted_q;
  logic [rrfa_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [rrfa_pkg::SumW-1:0]    in_sum_q, in_sum_d, out_sum_q, out_sum_d;
  logic [rrfa_pkg::SumXW-1:0]   in_x, out_x;
  logic                         free;

  assign free   = !res_valid_q || res_ready_i;
  assign take_o = stage_i.valid && free;

  always_comb begin
    in_x  = {1'b0, in_sum_q}  + rrfa_pkg::SumXW'(stage_i.in_add);
    out_x = {1'b0, out_sum_q} + rrfa_pkg::SumXW'(stage_i.out_add);
    cnt_d     = cnt_q;
    in_sum_d  = in_sum_q;
    out_sum_d = out_sum_q;
    if (take_o && stage_i.ok) begin
      if (cnt_q != '1) begin
        cnt_d = cnt_q + rrfa_pkg::CntW'(1);
      end
      in_sum_d  = in_x[rrfa_pkg::SumW]  ? '1 : in_x[rrfa_pkg::SumW-1:0];
      out_sum_d = out_x[rrfa_pkg::SumW] ? '1 : out_x[rrfa_pkg::SumW-1:0];
    end
    res_valid_d = res_valid_q;
    if (take_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      cnt_q       <= '0;
      in_sum_q    <= '0;
      out_sum_q   <= '0;
    end else begin
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
      in_sum_q    <= in_sum_d;
      out_sum_q   <= out_sum_d;
      if (take_o) begin
        accepted_q <= stage_i.ok;
      end
    end
  end

  assign res_valid_o       = res_valid_q;
  assign accepted_o        = accepted_q;
  assign access_total_o    = cnt_q;
  assign in_bytes_total_o  = in_sum_q;
  assign out_bytes_total_o = out_sum_q;

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && !stage_i.ok |=> $stable(cnt_q) && $stable(in_sum_q) && $stable(out_sum_q))
    else $error("totals moved on a rejected item");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && stage_i.ok && (cnt_q != '1) |=> cnt_q == $past(cnt_q) + rrfa_pkg::CntW'(1))
    else $error("access count did not step on an accepted item");

  a_sums_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> (in_sum_q >= $past(in_sum_q)) && (out_sum_q >= $past(out_sum_q)))
    else $error("byte total decreased");

  a_accepted_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && accepted_q |-> cnt_q != '0)
    else $error("accepted result with zero access count");

endmodule

`default_nettype wire

FILE: hdl/record_range_filter_accumulator.sv
// Top level: record range filter with saturating access and byte totals.
//
//  channel  dir  handshake    payload
//  rec_i    in   valid/ready  record_epoch, record_delay, record_in_bytes, record_out_bytes
//  res_o    out  valid/ready  accepted, access_total, in_bytes_total, out_bytes_total
//  cfg_i    in   valid/ready  index (0..7 bound registers, others dropped), data
//
// One item per cycle sustained while res_o is ready; each item passes the input
// register, then the bound compares and saturating adders feed the result register.
// Reset clears the totals and disables all bounds; no clearing pass.
// A stall on res_o backs up through the input register to rec_i.ready.
// cfg_i is always ready; write bounds only while no item is in flight.
`default_nettype none

module record_range_filter_accumulator (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  rrfa_rec_if.sink  rec_i,
  rrfa_res_if.source res_o,
  rrfa_cfg_if.sink  cfg_i
);

  rrfa_pkg::bounds_t bounds;
  rrfa_pkg::record_t rec;
  rrfa_pkg::stage_t  stage;
  logic              take;
  logic              load;

  assign cfg_i.ready = 1'b1;

  assign rec.epoch    = rec_i.record_epoch;
  assign rec.delay    = rec_i.record_delay;
  assign rec.in_size  = rec_i.record_in_bytes;
  assign rec.out_size = rec_i.record_out_bytes;

  assign rec_i.ready = !stage.valid || take;
  assign load        = rec_i.valid && rec_i.ready;

  rrfa_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (cfg_i.valid),
    .idx_i    (cfg_i.index),
    .data_i   (cfg_i.data),
    .bounds_o (bounds)
  );

  rrfa_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .take_i   (take),
    .rec_i    (rec),
    .bounds_i (bounds),
    .stage_o  (stage)
  );

  rrfa_accum u_accum (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .stage_i           (stage),
    .take_o            (take),
    .res_valid_o       (res_o.valid),
    .res_ready_i       (res_o.ready),
    .accepted_o        (res_o.accepted),
    .access_total_o    (res_o.access_total),
    .in_bytes_total_o  (res_o.in_bytes_total),
    .out_bytes_total_o (res_o.out_bytes_total)
  );

endmodule

`default_nettype wire

FILE: test/tb_record_range_filter_accumulator.sv
// Testbench for the record range filter: bound checks and saturating totals.
`timescale 1ns / 100ps

module tb_record_range_filter_accumulator;

  localparam int     ClkHalf      = 5;
  localparam int     StallLimit   = 2000;
  localparam longint WideMax      = (longint'(1) << rrfa_pkg::EpochW) - 1;
  localparam longint DelayMax     = (longint'(1) << rrfa_pkg::DelayW) - 1;
  localparam int     PhaseDefault = 0;
  localparam int     PhaseEdges   = 1;
  localparam int     PhaseFull    = 2;
  localparam int     PhaseTop     = 3;
  localparam int     PhaseNegOut  = 4;
  localparam int     PhaseOutLow  = 5;
  localparam int     PhaseCount   = 15;

  typedef struct packed {
    logic                      accepted;
    logic [rrfa_pkg::CntW-1:0] access_total;
    logic [rrfa_pkg::SumW-1:0] in_bytes_total;
    logic [rrfa_pkg::SumW-1:0] out_bytes_total;
  } totals_t;

  logic clk = 1'b0;
  logic rst_n;

  rrfa_rec_if rec_if ();
  rrfa_res_if res_if ();
  rrfa_cfg_if cfg_if ();

  record_range_filter_accumulator u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rec_i (rec_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always #(ClkHalf) clk = ~clk;

  // Shadow of the bound registers (sign-extended) and of the running totals
  longint                    bound_val [0:rrfa_pkg::REG_DELAY_HIGH];
  logic [rrfa_pkg::CntW-1:0] access_cnt;
  logic [rrfa_pkg::SumW-1:0] in_sum;
  logic [rrfa_pkg::SumW-1:0] out_sum;

  rrfa_pkg::record_t pending_records [$];
  totals_t           expected_totals [$];
  longint            plan [0:rrfa_pkg::REG_DELAY_HIGH];

  int records_queued = 0;
  int records_taken  = 0;
  int mismatch_cnt   = 0;
  int stall_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit rec_took       = 1'b0;

  function automatic longint rand_upto(longint n);
    logic [63:0] r;
    if (n <= 0) return 0;
    r = {$urandom(), $urandom()};
    return longint'(r % (n + 1));
  endfunction

  function automatic bit in_window(longint v, int lo_idx);
    longint lo;
    longint hi;
    lo = bound_val[lo_idx];
    hi = bound_val[lo_idx + 1];
    return !((lo >= 0 && v < lo) || (hi >= 0 && v >= hi));
  endfunction

  function automatic logic [rrfa_pkg::SumW-1:0] sat_add(logic [rrfa_pkg::SumW-1:0] sum,
                                                        longint add);
    logic [rrfa_pkg::SumW:0] s;
    s = {1'b0, sum} + rrfa_pkg::SumXW'(add);
    return s[rrfa_pkg::SumW] ? {rrfa_pkg::SumW{1'b1}} : s[rrfa_pkg::SumW-1:0];
  endfunction

  // Applies one record to the shadow totals and returns the result item it yields
  function automatic totals_t filter_record(rrfa_pkg::record_t r);
    longint  epoch_v;
    longint  delay_v;
    longint  in_v;
    longint  out_v;
    longint  out_eff;
    totals_t t;
    epoch_v = longint'(r.epoch);
    delay_v = longint'(r.delay);
    in_v    = longint'(r.in_size);
    out_v   = longint'($signed(r.out_size));
    // outgoing bounds see the raw count, before -1 stands for incoming
    t.accepted = in_window(epoch_v, rrfa_pkg::REG_EPOCH_LOW) &&
                 in_window(in_v, rrfa_pkg::REG_IN_BYTES_LOW) &&
                 in_window(out_v, rrfa_pkg::REG_OUT_BYTES_LOW) &&
                 in_window(delay_v, rrfa_pkg::REG_DELAY_LOW);
    if (t.accepted) begin
      out_eff = (out_v == -1) ? in_v : out_v;
      if (access_cnt != {rrfa_pkg::CntW{1'b1}}) access_cnt++;
      in_sum = sat_add(in_sum, in_v);
      if (out_eff > 0) out_sum = sat_add(out_sum, out_eff);
    end
    t.access_total    = access_cnt;
    t.in_bytes_total  = in_sum;
    t.out_bytes_total = out_sum;
    return t;
  endfunction

  function automatic rrfa_pkg::record_t mk_record(longint e, longint d, longint i,
                                                  longint o);
    rrfa_pkg::record_t r;
    r.epoch    = rrfa_pkg::EpochW'(e);
    r.delay    = rrfa_pkg::DelayW'(d);
    r.in_size  = rrfa_pkg::BytesW'(i);
    r.out_size = rrfa_pkg::OutW'(o);
    return r;
  endfunction

  // Field value biased toward the current bounds of that field
  function automatic longint pick_near(longint lo, longint hi, longint maxv);
    longint v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = maxv;
      2: v = (lo >= 0) ? lo - 1 + longint'($urandom_range(2)) : rand_upto(maxv);
      3: v = (hi >= 0) ? hi - 1 + longint'($urandom_range(2)) : rand_upto(maxv);
      default: begin
        if (lo >= 0 && hi > lo) v = lo + rand_upto(hi - lo - 1);
        else if (lo >= 0) v = lo + rand_upto(maxv - lo);
        else if (hi > 0) v = rand_upto(hi - 1);
        else v = rand_upto(maxv);
      end
    endcase
    if (v < 0) v = 0;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic rrfa_pkg::record_t make_record();
    longint o;
    int     sel;
    sel = $urandom_range(99);
    if (sel < 15) o = -1;
    else if (sel < 20) o = -2 - rand_upto(WideMax - 1);
    else o = pick_near(bound_val[rrfa_pkg::REG_OUT_BYTES_LOW],
                       bound_val[rrfa_pkg::REG_OUT_BYTES_HIGH], WideMax);
    return mk_record(
      pick_near(bound_val[rrfa_pkg::REG_EPOCH_LOW], bound_val[rrfa_pkg::REG_EPOCH_HIGH],
                WideMax),
      pick_near(bound_val[rrfa_pkg::REG_DELAY_LOW], bound_val[rrfa_pkg::REG_DELAY_HIGH],
                DelayMax),
      pick_near(bound_val[rrfa_pkg::REG_IN_BYTES_LOW],
                bound_val[rrfa_pkg::REG_IN_BYTES_HIGH], WideMax),
      o);
  endfunction

  task automatic queue_record(rrfa_pkg::record_t r);
    pending_records.push_back(r);
    records_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (records_taken != records_queued || expected_totals.size() != 0);
  endtask

  task automatic write_reg(logic [rrfa_pkg::IdxW-1:0] idx,
                           logic [rrfa_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic random_pair(int i, longint maxv);
    int     shape;
    longint span;
    shape       = $urandom_range(4);
    plan[i]     = $urandom_range(1) ? -1 : -1 - rand_upto(maxv);
    plan[i + 1] = $urandom_range(1) ? -1 : -1 - rand_upto(maxv);
    if (shape == 1 || shape >= 3) plan[i] = rand_upto(maxv);
    if (shape >= 3) begin
      span = maxv - plan[i];
      if ($urandom_range(1) && span > 1000) span = 1000;
      plan[i + 1] = plan[i] + 1 + rand_upto(span);
      if (plan[i + 1] > maxv) plan[i + 1] = maxv;
    end else if (shape == 2) begin
      plan[i + 1] = rand_upto(maxv);
    end
  endtask

  task automatic plan_bounds(int phase);
    longint maxv;
    for (int i = rrfa_pkg::REG_EPOCH_LOW; i <= rrfa_pkg::REG_DELAY_HIGH; i += 2) begin
      maxv = (i == rrfa_pkg::REG_DELAY_LOW) ? DelayMax : WideMax;
      case (phase)
        PhaseEdges: begin
          plan[i]     = 100;
          plan[i + 1] = 200;
        end
        PhaseFull: begin
          plan[i]     = 0;
          plan[i + 1] = maxv;
        end
        PhaseTop: begin
          plan[i]     = maxv;
          plan[i + 1] = -1;
        end
        PhaseNegOut: begin
          // most negative low; only negative outgoing counts pass
          plan[i]     = -maxv - 1;
          plan[i + 1] = (i == rrfa_pkg::REG_OUT_BYTES_LOW) ? 0 : -2;
        end
        PhaseOutLow: begin
          plan[i]     = (i == rrfa_pkg::REG_OUT_BYTES_LOW) ? 0 : -1;
          plan[i + 1] = -1;
        end
        default: random_pair(i, maxv);
      endcase
    end
  endtask

  task automatic apply_plan();
    logic [rrfa_pkg::CfgDataW-1:0] word;
    for (int i = rrfa_pkg::REG_EPOCH_LOW; i <= rrfa_pkg::REG_DELAY_HIGH; i++) begin
      word = rrfa_pkg::CfgDataW'(plan[i]);
      // bits above the delay bound width are don't-care
      if (i >= rrfa_pkg::REG_DELAY_LOW) begin
        word[rrfa_pkg::CfgDataW-1:rrfa_pkg::DelayBoundW] = $urandom();
      end
      write_reg(rrfa_pkg::IdxW'(i), word);
    end
    write_reg(rrfa_pkg::IdxW'($urandom_range(rrfa_pkg::REG_DELAY_HIGH + 1,
                                             (1 << rrfa_pkg::IdxW) - 1)),
              rrfa_pkg::CfgDataW'({$urandom(), $urandom()}));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Record driver and result-side ready, both switched on the falling edge
  always @(negedge clk) begin
    rrfa_pkg::record_t nxt;
    if (!rec_if.valid || rec_took) begin
      if (pending_records.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_records.pop_front();
        rec_if.valid            <= 1'b1;
        rec_if.record_epoch     <= nxt.epoch;
        rec_if.record_delay     <= nxt.delay;
        rec_if.record_in_bytes  <= nxt.in_size;
        rec_if.record_out_bytes <= nxt.out_size;
      end else begin
        rec_if.valid <= 1'b0;
      end
    end
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: config shadow, prediction, result compare and watchdog
  always @(posedge clk) begin
    totals_t           want;
    rrfa_pkg::record_t taken_rec;
    bit                res_took;
    bit                cfg_took;
    if (!rst_n) begin
      foreach (bound_val[i]) bound_val[i] = -1;
      access_cnt   = '0;
      in_sum       = '0;
      out_sum      = '0;
      rec_took     = 1'b0;
      stall_cycles = 0;
    end else begin
      rec_took = rec_if.valid && rec_if.ready;
      res_took = res_if.valid && res_if.ready;
      cfg_took = cfg_if.valid && cfg_if.ready;
      if (cfg_took) begin
        case (cfg_if.index)
          rrfa_pkg::REG_DELAY_LOW, rrfa_pkg::REG_DELAY_HIGH:
            bound_val[cfg_if.index[2:0]] =
              longint'($signed(cfg_if.data[rrfa_pkg::DelayBoundW-1:0]));
          rrfa_pkg::REG_EPOCH_LOW, rrfa_pkg::REG_EPOCH_HIGH,
          rrfa_pkg::REG_IN_BYTES_LOW, rrfa_pkg::REG_IN_BYTES_HIGH,
          rrfa_pkg::REG_OUT_BYTES_LOW, rrfa_pkg::REG_OUT_BYTES_HIGH:
            bound_val[cfg_if.index[2:0]] = longint'($signed(cfg_if.data));
          default: ;
        endcase
      end
      if (res_took) begin
        if (expected_totals.size() == 0) begin
          $error("result item with no expectation pending");
          mismatch_cnt++;
        end else begin
          want = expected_totals.pop_front();
          check_field("accepted", want.accepted, res_if.accepted);
          check_field("access_total", want.access_total, res_if.access_total);
          check_field("in_bytes_total", want.in_bytes_total, res_if.in_bytes_total);
          check_field("out_bytes_total", want.out_bytes_total, res_if.out_bytes_total);
        end
      end
      if (rec_took) begin
        taken_rec = '{epoch: rec_if.record_epoch, delay: rec_if.record_delay,
                      in_size: rec_if.record_in_bytes, out_size: rec_if.record_out_bytes};
        expected_totals.push_back(filter_record(taken_rec));
        records_taken++;
      end
      if (rec_took || res_took || cfg_took) begin
        stall_cycles = 0;
      end else if (++stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    rst_n                   = 1'b0;
    rec_if.valid            = 1'b0;
    rec_if.record_epoch     = '0;
    rec_if.record_delay     = '0;
    rec_if.record_in_bytes  = '0;
    rec_if.record_out_bytes = '0;
    res_if.ready            = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = '0;
    cfg_if.data             = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = PhaseDefault; p < PhaseCount; p++) begin
      if (p != PhaseDefault) begin
        plan_bounds(p);
        apply_plan();
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      n = 120;
      if (p == PhaseDefault) begin
        // all bounds off: extremes, -1 substitution, other negatives add nothing
        queue_record(mk_record(0, 0, 0, 0));
        queue_record(mk_record(WideMax, DelayMax, WideMax, WideMax));
        queue_record(mk_record(5, 5, 1000, -1));
        queue_record(mk_record(5, 5, 1000, -7));
        queue_record(mk_record(5, 5, 77, -WideMax - 1));
        queue_record(mk_record(5, 5, 3, 0));
        n = 40;
      end else if (p == PhaseEdges) begin
        // inclusive low, exclusive high on each field
        for (longint v = 99; v <= 200; v += ((v == 100) ? 99 : 1)) begin
          queue_record(mk_record(v, 150, 150, 150));
          queue_record(mk_record(150, v, 150, 150));
          queue_record(mk_record(150, 150, v, 150));
          queue_record(mk_record(150, 150, 150, v));
        end
        queue_record(mk_record(150, 150, 150, -1));
        n = 60;
      end else if (p <= PhaseOutLow) begin
        n = 110;
      end
      repeat (n) queue_record(make_record());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (expected_totals.size() != 0) begin
      $error("%0d expected result items never arrived", expected_totals.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/rrfa_pkg.sv
hdl/rrfa_if.sv
hdl/rrfa_cfg_regs.sv
hdl/rrfa_filter.sv
hdl/rrfa_accum.sv
hdl/record_range_filter_accumulator.sv
test/tb_record_range_filter_accumulator.sv
